// ===== rtl/core/rsch_pkg.sv =====
// Shared types and constants for the ray/sphere nearest-hit block.
package rsch_pkg;

    // Sizing of the query.
    localparam int MAX_SPHERES = 256;
    localparam int FRAC_BITS   = 16;
    localparam int CNT_W       = $clog2(MAX_SPHERES + 2);
    localparam int IDX_W       = 8;

    // Interior arithmetic widths.
    localparam int SUM_W  = 128;
    localparam int ROOT_W = 64;
    localparam int REM_W  = 68;
    localparam int PROD_W = 66;
    localparam int OPD_W  = 33;

    // Smallest accepted root, at 2*FRAC_BITS fraction bits.
    localparam logic signed [63:0] EPS = 64'sd1 <<< (2 * FRAC_BITS - 14);

    // Queue depth between the front and the arithmetic engine.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Command codes.
    localparam logic CMD_BEGIN  = 1'b0;
    localparam logic CMD_SPHERE = 1'b1;

    // Stream widths.
    localparam int IN_DATA_W  = 280;
    localparam int OUT_DATA_W = 48;

    // One queued transaction.
    typedef struct packed {
        logic               command;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] dir_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic        [30:0] radius;
        logic               last_sphere;
    } item_t;

    // One query result.
    typedef struct packed {
        logic        index_overflow;
        logic [31:0] hit_distance;
        logic [7:0]  sphere_index;
        logic        hit;
    } result_t;

endpackage

// ===== rtl/core/rsch_queue.sv =====
// Short queue that decouples the accepting front from the arithmetic engine.
module rsch_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rsch_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rsch_pkg::item_t pop_item
);
    import rsch_pkg::*;

    item_t               mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W:0]     count_reg;

    assign full     = (count_reg == (QPTR_W + 1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    // Storage is written at the write pointer only.
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    // Pointer and fill count bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if ((push && !full) && !(pop && !empty))
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/rsch_engine.sv =====
// Back end: per-sphere intersection math, nearest-hit tracking and result register.
module rsch_engine
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  rsch_pkg::item_t  item,
    output logic             item_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output rsch_pkg::result_t res
);
    import rsch_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_PICK = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    // Multiply sequence step codes.
    localparam logic [3:0] OP_PD0 = 4'd1;
    localparam logic [3:0] OP_PD2 = 4'd3;
    localparam logic [3:0] OP_PP0 = 4'd4;
    localparam logic [3:0] OP_PP2 = 4'd6;
    localparam logic [3:0] OP_RR  = 4'd7;
    localparam logic [3:0] OP_BLL = 4'd8;
    localparam logic [3:0] OP_BHL = 4'd9;
    localparam logic [3:0] OP_BHH = 4'd10;
    localparam logic [3:0] OP_END = 4'd11;

    logic [2:0]              state_reg;
    logic signed [31:0]      origin_reg [3];
    logic signed [17:0]      dir_reg [3];
    logic [31:0]             best_dist_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic                    any_hit_reg;
    logic [CNT_W-1:0]        count_reg;
    item_t                   cur_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic [OPD_W-1:0]        pmag_reg [3];
    logic                    psgn_reg [3];
    logic [3:0]              op_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic                    prod_neg_reg;
    logic signed [63:0]      b_reg;
    logic [SUM_W-1:0]        s1_reg;
    logic [SUM_W-1:0]        s2_reg;
    logic [SUM_W-1:0]        rad_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [5:0]              iter_reg;
    logic                    cand_hit_reg;
    logic [31:0]             cand_dist_reg;
    logic                    res_valid_reg;
    result_t                 res_reg;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign item_pop  = (state_reg == ST_IDLE) && item_valid;

    // Operand selection for the shared multiplier.
    logic [OPD_W-1:0]  opa;
    logic [OPD_W-1:0]  opb;
    logic              op_neg;
    logic [63:0]       bmag;
    logic [1:0]        lane;
    logic [OPD_W-1:0]  dmag [3];

    always_comb
    begin
        bmag = b_reg[63] ? 64'(-b_reg) : 64'(b_reg);
        for (int i = 0; i < 3; i++)
        begin
            dmag[i] = dir_reg[i][17] ? OPD_W'(-33'(dir_reg[i])) : OPD_W'(dir_reg[i]);
        end
        lane   = 2'd0;
        opa    = '0;
        opb    = '0;
        op_neg = 1'b0;
        if (op_reg >= OP_PD0 && op_reg <= OP_PD2)
        begin
            lane   = 2'(op_reg - OP_PD0);
            opa    = pmag_reg[lane];
            opb    = dmag[lane];
            op_neg = psgn_reg[lane] ^ dir_reg[lane][17];
        end
        else if (op_reg >= OP_PP0 && op_reg <= OP_PP2)
        begin
            lane = 2'(op_reg - OP_PP0);
            opa  = pmag_reg[lane];
            opb  = pmag_reg[lane];
        end
        else if (op_reg == OP_RR)
        begin
            opa = OPD_W'(cur_reg.radius);
            opb = OPD_W'(cur_reg.radius);
        end
        else if (op_reg == OP_BLL)
        begin
            opa = OPD_W'(bmag[31:0]);
            opb = OPD_W'(bmag[31:0]);
        end
        else if (op_reg == OP_BHL)
        begin
            opa = OPD_W'(bmag[63:32]);
            opb = OPD_W'(bmag[31:0]);
        end
        else if (op_reg == OP_BHH)
        begin
            opa = OPD_W'(bmag[63:32]);
            opb = OPD_W'(bmag[63:32]);
        end
    end

    // Differences, square-root step and root selection.
    logic signed [32:0]  diff [3];
    logic [SUM_W-1:0]    s2_shift;
    logic [REM_W-1:0]    rem_try;
    logic [REM_W-1:0]    trial;
    logic signed [63:0]  t_lo;
    logic signed [63:0]  t_hi;
    logic signed [63:0]  t_sel;
    logic [47:0]         q;
    logic                take;
    logic [CNT_W-1:0]    idx_full;
    logic                begin_clear;

    always_comb
    begin
        diff[0] = 33'(item.center_x) - 33'(origin_reg[0]);
        diff[1] = 33'(item.center_y) - 33'(origin_reg[1]);
        diff[2] = 33'(item.center_z) - 33'(origin_reg[2]);
        s2_shift = s2_reg << (2 * FRAC_BITS);
        rem_try  = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        t_lo     = b_reg - $signed({1'b0, root_reg[62:0]});
        t_hi     = b_reg + $signed({1'b0, root_reg[62:0]});
        t_sel    = (t_lo >= EPS) ? t_lo : t_hi;
        q        = t_sel[63:FRAC_BITS];
        take     = cand_hit_reg && (!any_hit_reg || cand_dist_reg < best_dist_reg);
        idx_full = (count_reg < CNT_W'(MAX_SPHERES)) ? count_reg : CNT_W'(MAX_SPHERES - 1);
        begin_clear = 1'b0;
    end

    // Engine sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                origin_reg[i] <= '0;
                dir_reg[i]    <= '0;
            end
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            any_hit_reg   <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            op_reg        <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        cur_reg <= item;
                        if (item.command == CMD_BEGIN || begin_clear)
                        begin
                            origin_reg[0] <= item.origin_x;
                            origin_reg[1] <= item.origin_y;
                            origin_reg[2] <= item.origin_z;
                            dir_reg[0]    <= item.dir_x;
                            dir_reg[1]    <= item.dir_y;
                            dir_reg[2]    <= item.dir_z;
                            best_dist_reg <= '1;
                            best_idx_reg  <= '0;
                            any_hit_reg   <= 1'b0;
                            count_reg     <= '0;
                        end
                        else
                        begin
                            // Take the arrival index and the differences.
                            idx_reg <= (idx_full > CNT_W'(255)) ? 8'hFF
                                                                : IDX_W'(idx_full);
                            if (count_reg < CNT_W'(MAX_SPHERES + 1))
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            for (int i = 0; i < 3; i++)
                            begin
                                psgn_reg[i] <= diff[i][32];
                                pmag_reg[i] <= diff[i][32] ? OPD_W'(-diff[i])
                                                           : OPD_W'(diff[i]);
                            end
                            state_reg <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF:
                begin
                    b_reg     <= '0;
                    s1_reg    <= '0;
                    s2_reg    <= '0;
                    op_reg    <= OP_PD0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    // Issue this step's product, fold in the previous one.
                    prod_reg     <= PROD_W'(opa) * PROD_W'(opb);
                    prod_neg_reg <= op_neg;
                    if (op_reg > OP_PD0 && op_reg <= OP_PP0)
                    begin
                        b_reg <= prod_neg_reg ? b_reg - 64'(prod_reg) : b_reg + 64'(prod_reg);
                    end
                    else if (op_reg > OP_PP0 && op_reg <= OP_RR)
                    begin
                        s2_reg <= s2_reg + SUM_W'(prod_reg);
                    end
                    else if (op_reg == OP_BLL)
                    begin
                        s1_reg <= s1_reg + (SUM_W'(prod_reg) << (2 * FRAC_BITS));
                    end
                    else if (op_reg == OP_BHL)
                    begin
                        s1_reg <= s1_reg + SUM_W'(prod_reg);
                    end
                    else if (op_reg == OP_BHH)
                    begin
                        s1_reg <= s1_reg + (SUM_W'(prod_reg) << 33);
                    end
                    else if (op_reg == OP_END)
                    begin
                        s1_reg <= s1_reg + (SUM_W'(prod_reg) << 64);
                    end
                    if (op_reg == OP_END)
                    begin
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        op_reg <= op_reg + 1'b1;
                    end
                end
                ST_CMP:
                begin
                    // A negative discriminant is a miss.
                    rad_reg   <= s1_reg - s2_shift;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    iter_reg  <= '1;
                    cand_hit_reg <= 1'b0;
                    state_reg <= (s1_reg < s2_shift) ? ST_DONE : ST_SQRT;
                end
                ST_SQRT:
                begin
                    // One result bit of the integer square root per cycle.
                    rad_reg <= rad_reg << 2;
                    if (rem_try >= trial)
                    begin
                        rem_reg  <= rem_try - trial;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_try;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    iter_reg <= iter_reg - 1'b1;
                    if (iter_reg == '0)
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    cand_hit_reg  <= (t_lo >= EPS) || (t_hi >= EPS);
                    cand_dist_reg <= (q >= 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                    state_reg     <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!cur_reg.last_sphere)
                    begin
                        if (take)
                        begin
                            best_dist_reg <= cand_dist_reg;
                            best_idx_reg  <= idx_reg;
                            any_hit_reg   <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else if (!res_valid_reg)
                    begin
                        // Emit the query result and clear for the next query.
                        res_valid_reg          <= 1'b1;
                        res_reg.hit            <= take ? 1'b1 : any_hit_reg;
                        res_reg.sphere_index   <= take ? idx_reg : best_idx_reg;
                        res_reg.hit_distance   <= take ? cand_dist_reg : best_dist_reg;
                        res_reg.index_overflow <= (count_reg > CNT_W'(MAX_SPHERES));
                        best_dist_reg <= '1;
                        best_idx_reg  <= '0;
                        any_hit_reg   <= 1'b0;
                        count_reg     <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/ray_sphere_closest_hit.sv =====
// Top level of the ray/sphere nearest-hit block: stream front end and engine.
//
// Usage: the slave stream carries one transaction per item. tuser is the
// command (0 begins a new ray query, 1 tests one sphere) and tlast marks
// the final sphere of a query. A begin loads the ray origin and direction
// and clears the running nearest hit; each sphere after it is tested and
// the nearest hit is kept, the earlier sphere winning ties.
// The master stream carries one result per query, after its last sphere:
// hit flag, sphere index, distance (Q16.16, all ones on a miss or when
// saturated) and an index overflow flag.
// A begin is taken in the engine's idle state; a sphere passes through
// the 11-step shared multiplier sequence and the 64-step bit-serial
// square root, and a sphere with a negative discriminant skips the
// square root. The last sphere of a query passes through the queue
// and the engine steps before the result goes to the output register.
// A two-entry queue accepts input while the engine works. When the
// receiver stalls, the result is held in the output register and the
// engine waits before giving the next result; input still fills the queue.
// Reset clears the ray to zero and the query state to no hit.
module ray_sphere_closest_hit
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, sphere_center_x/y/z, sphere_radius, pad.
    input  logic [rsch_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command.
    input  logic                             s_axis_tuser,
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hit, sphere_index, hit_distance, index_overflow, pad.
    output logic [rsch_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import rsch_pkg::*;

    item_t    in_item;
    item_t    q_item;
    logic     q_full;
    logic     q_empty;
    logic     q_pop;
    result_t  result;

    // Unpack the incoming transaction.
    always_comb
    begin
        in_item.command     = s_axis_tuser;
        in_item.origin_x    = s_axis_tdata[31:0];
        in_item.origin_y    = s_axis_tdata[63:32];
        in_item.origin_z    = s_axis_tdata[95:64];
        in_item.dir_x       = s_axis_tdata[113:96];
        in_item.dir_y       = s_axis_tdata[131:114];
        in_item.dir_z       = s_axis_tdata[149:132];
        in_item.center_x    = s_axis_tdata[181:150];
        in_item.center_y    = s_axis_tdata[213:182];
        in_item.center_z    = s_axis_tdata[245:214];
        in_item.radius      = s_axis_tdata[276:246];
        in_item.last_sphere = s_axis_tlast;
    end

    assign s_axis_tready = !q_full;

    rsch_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (q_item)
    );

    rsch_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (!q_empty),
        .item       (q_item),
        .item_pop   (q_pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (result)
    );

    // Pack the result transaction.
    assign m_axis_tdata = {6'b0, result.index_overflow, result.hit_distance,
                           result.sphere_index, result.hit};

endmodule
